>>> hw/rtl/palette_rle_sprite_decoder_unit_defines.svh
// Assertion helpers for the decoder top module.
`ifndef PALETTE_RLE_SPRITE_DECODER_UNIT_DEFINES_SVH
`define PALETTE_RLE_SPRITE_DECODER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PRSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define PRSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/prsd_pkg.sv
package prsd_pkg;

  localparam int PaletteDepthDefault = 256;
  localparam int CmdQueueDepth       = 2;

  // Input operation codes.
  localparam logic [1:0] OpPalWrite = 2'd0;
  localparam logic [1:0] OpFrame    = 2'd1;
  localparam logic [1:0] OpStream   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KindTransparent = 2'd0;
  localparam logic [1:0] KindOpaque      = 2'd1;
  localparam logic [1:0] KindError       = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [7:0]  entry_slot;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] position;
    logic [7:0]  run_length;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  color_index;
  } result_t;

  // Work handed from the parser to the palette side. For a palette write,
  // index is the slot and the color fields carry the entry.
  typedef struct packed {
    logic        is_write;
    logic [1:0]  kind;
    logic [31:0] position;
    logic [7:0]  run_length;
    logic [7:0]  alpha;
    logic [7:0]  index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cmd_t;

endpackage

>>> hw/rtl/palette_rle_sprite_decoder_unit.sv
// Paletted run-length sprite decoder.
// Input queue side: push an item while full is low. Palette writes load the
// color store, a frame start sets width and height, and stream bytes (size,
// alpha, then one index per opaque pixel) are parsed into results.
// Result queue side: while empty is low the oldest result is on result_o;
// pop takes it. Transparent runs, opaque pixels and overrun errors come out
// in stream order; items that give no result leave nothing on this side.
// Timing: one item per cycle while full is low. The parser decides each
// item in the cycle it is taken and hands work to a two-entry command
// queue; the palette side reads its single-port color store once per
// opaque command and registers the result, so each result passes through
// the command queue and then the result register before it is on result_o.
// When pop stays low the result register holds, palette writes still drain,
// and once the command queue fills, full rises until a result is taken.
// Reset clears the parser, queue pointers and result valid flag; the palette
// contents are not cleared and must be written before they are used.
`include "palette_rle_sprite_decoder_unit_defines.svh"

module palette_rle_sprite_decoder_unit import prsd_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  logic out_stalled;
  logic out_opaque;
  logic out_black;

  assign accept = push && !full;

  prsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  prsd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && cmd_valid),
    .push_data_i(cmd),
    .pop_i      (cmd_pop),
    .head_o     (cmd_head),
    .full_o     (full),
    .empty_o    (cmd_empty)
  );

  prsd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

  assign out_stalled = !empty && !pop;
  assign out_opaque  = (result_o.kind == KindOpaque);
  assign out_black   = (result_o.red == '0) && (result_o.green == '0) && (result_o.blue == '0);

  `PRSD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> empty && !full, "reset left queues busy")
  `PRSD_ASSERT(a_hold_only_writes, cmd_pop && out_stalled |-> cmd_head.is_write, "result replaced")
  `PRSD_ASSERT(a_opaque_len, !empty && out_opaque |-> result_o.run_length == 8'd1, "bad opaque length")
  `PRSD_ASSERT(a_plain_no_color, !empty && !out_opaque |-> out_black, "color on non-opaque result")

endmodule

>>> hw/rtl/prsd_front.sv
module prsd_front import prsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  item_t item_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o
);

  localparam logic [1:0] PhSize   = 2'd0;
  localparam logic [1:0] PhAlpha  = 2'd1;
  localparam logic [1:0] PhIndex  = 2'd2;
  localparam logic [1:0] PhIgnore = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  alpha_q, alpha_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] frame_pixels_q, frame_pixels_d;
  logic [31:0] product;
  logic [7:0]  remain_dec;

  assign product    = item_i.frame_width * item_i.frame_height;
  assign remain_dec = remain_q - 8'd1;

  always_comb begin
    phase_d        = phase_q;
    remain_d       = remain_q;
    alpha_d        = alpha_q;
    pos_d          = pos_q;
    frame_pixels_d = frame_pixels_q;
    cmd_valid_o    = 1'b0;
    cmd_o          = '0;
    case (item_i.op)
      OpPalWrite: begin
        cmd_valid_o    = 1'b1;
        cmd_o.is_write = 1'b1;
        cmd_o.index    = item_i.entry_slot;
        cmd_o.red      = item_i.entry_red;
        cmd_o.green    = item_i.entry_green;
        cmd_o.blue     = item_i.entry_blue;
      end
      OpFrame: begin
        frame_pixels_d = product;
        pos_d          = '0;
        remain_d       = '0;
        alpha_d        = '0;
        // An empty frame is known from the factors, without the product.
        phase_d = (item_i.frame_width == '0 || item_i.frame_height == '0) ? PhIgnore : PhSize;
      end
      OpStream: begin
        unique case (phase_q)
          PhSize: begin
            if (pos_q > frame_pixels_q) begin
              phase_d        = PhIgnore;
              cmd_valid_o    = 1'b1;
              cmd_o.kind     = KindError;
              cmd_o.position = pos_q;
            end else begin
              remain_d = item_i.data_byte;
              phase_d  = PhAlpha;
            end
          end
          PhAlpha: begin
            if (item_i.data_byte == '0) begin
              cmd_valid_o      = 1'b1;
              cmd_o.kind       = KindTransparent;
              cmd_o.position   = pos_q;
              cmd_o.run_length = remain_q;
              pos_d            = pos_q + 32'(remain_q);
              remain_d         = '0;
              phase_d          = PhSize;
            end else if (remain_q == '0) begin
              phase_d = PhSize;
            end else begin
              alpha_d = item_i.data_byte;
              phase_d = PhIndex;
            end
          end
          PhIndex: begin
            cmd_valid_o      = 1'b1;
            cmd_o.kind       = KindOpaque;
            cmd_o.position   = pos_q;
            cmd_o.run_length = 8'd1;
            cmd_o.alpha      = alpha_q;
            cmd_o.index      = item_i.data_byte;
            pos_d            = pos_q + 32'd1;
            remain_d         = remain_dec;
            if (remain_dec == '0) begin
              phase_d = PhSize;
            end
          end
          PhIgnore: begin
            phase_d = PhIgnore;
          end
          default: begin
            phase_d = PhIgnore;
          end
        endcase
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhSize;
      remain_q       <= '0;
      alpha_q        <= '0;
      pos_q          <= '0;
      frame_pixels_q <= '0;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      remain_q       <= remain_d;
      alpha_q        <= alpha_d;
      pos_q          <= pos_d;
      frame_pixels_q <= frame_pixels_d;
    end
  end

endmodule

>>> hw/rtl/prsd_queue.sv
module prsd_queue import prsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(CmdQueueDepth);
  localparam int CntW = $clog2(CmdQueueDepth + 1);

  cmd_t            slots_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(CmdQueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/prsd_back.sv
module prsd_back import prsd_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_empty_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  localparam int IdxW = $clog2(PALETTE_DEPTH);

  logic [23:0]     palette_q [PALETTE_DEPTH];
  logic [23:0]     rdata_q;
  logic            in_range;
  logic            load;
  logic            out_valid_q;
  logic            color_ok_q;
  logic [1:0]      kind_q;
  logic [31:0]     position_q;
  logic [7:0]      run_length_q;
  logic [7:0]      alpha_q;
  logic [7:0]      index_q;
  logic [IdxW-1:0] addr;

  assign in_range = ({24'b0, cmd_i.index} < 32'(PALETTE_DEPTH));
  assign addr     = cmd_i.index[IdxW-1:0];

  // Palette writes never touch the output register, so they drain even
  // while a result waits.
  assign cmd_pop_o = !cmd_empty_i && (cmd_i.is_write || !out_valid_q || pop_i);
  assign load      = cmd_pop_o && !cmd_i.is_write;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_write && in_range) begin
      palette_q[addr] <= {cmd_i.red, cmd_i.green, cmd_i.blue};
    end
    if (load && cmd_i.kind == KindOpaque) begin
      rdata_q <= palette_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q       <= cmd_i.kind;
      position_q   <= cmd_i.position;
      run_length_q <= cmd_i.run_length;
      alpha_q      <= cmd_i.alpha;
      index_q      <= cmd_i.index;
      color_ok_q   <= (cmd_i.kind == KindOpaque) && in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    result_o             = '0;
    result_o.kind        = kind_q;
    result_o.position    = position_q;
    result_o.run_length  = run_length_q;
    result_o.alpha       = alpha_q;
    result_o.color_index = index_q;
    if (color_ok_q) begin
      result_o.red   = rdata_q[23:16];
      result_o.green = rdata_q[15:8];
      result_o.blue  = rdata_q[7:0];
    end
  end

endmodule
